// ===== hw/rtl/ptc_pkg.sv =====
// Shared types and constants for the pressure and temperature compensation block.
// Used by the divider cells, the divider chain and the top level. No dependencies.
package ptc_pkg;

    // Divider chain geometry: one quotient bit per cell.
    localparam int DIV_STEPS = 32;
    localparam int DIV_NW    = 32;
    localparam int DIV_DW    = 18;
    localparam int PASS_W    = 40;

    // Configuration data width (widest register).
    localparam int CFG_DW = 48;

    // One slot of a divider chain together with the data riding along with it.
    typedef struct packed {
        logic              vld;
        logic [DIV_DW-1:0] rem;
        logic [DIV_NW-1:0] nq;
        logic [DIV_DW-1:0] den;
        logic [PASS_W-1:0] pass;
    } t_div_lane;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_AC123 = 3'd0,
        CFG_AC456 = 3'd1,
        CFG_B1B2  = 3'd2,
        CFG_MCMD  = 3'd3,
        CFG_OSS   = 3'd4
    } t_cfg_idx;

    // Register values after reset (default calibration, oversampling 0).
    localparam logic [47:0] RST_AC123 = 48'd1756636956625;
    localparam logic [47:0] RST_AC456 = 48'd140623671024241;
    localparam logic [31:0] RST_B1B2  = 32'd405667844;
    localparam logic [31:0] RST_MCMD  = 32'd3724086068;
    localparam logic [1:0]  RST_OSS   = 2'd0;

    // Compensation constants.
    localparam logic signed [4:0]  T_ROUND    = 5'sd8;
    localparam logic signed [15:0] T_MAX      = 16'sd32767;
    localparam logic signed [15:0] T_MIN      = -16'sd32768;
    localparam logic signed [12:0] B6_OFFSET  = 13'sd4000;
    localparam logic signed [2:0]  RND_TWO    = 3'sd2;
    localparam logic signed [2:0]  RND_THREE  = 3'sd3;
    localparam logic [31:0]        W_OFFSET   = 32'd32768;
    localparam logic [15:0]        P_SCALE    = 16'd50000;
    localparam logic [11:0]        P_C1       = 12'd3038;
    localparam logic signed [13:0] P_C2       = -14'sd7357;
    localparam logic signed [12:0] P_C3       = 13'sd3791;
    localparam logic signed [18:0] PA_MAX     = 19'sd262143;

endpackage

// ===== hw/rtl/pressure_temp_compensation.sv =====
// Top level of the pressure and temperature compensation pipeline.
// Depends on ptc_pkg and ptc_divider (two divider chains).
//
//   channel  | valid        | ready        | payload
//   ---------+--------------+--------------+-------------------------------------------
//   input    | i_valid      | o_ready      | i_raw_temp, i_raw_pressure
//   result   | o_valid      | i_ready      | o_temp_tenths, o_pressure_pa, o_div_error
//   config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One sample pair is taken per cycle unless a full skid register holds the pipeline.
// Each result passes through the two 32-cell divider chains and 16 arithmetic stages.
// Reset clears all valid bits and loads the default calibration; no clearing pass.
// When a result is not taken, it moves to a skid register while the pipeline still
// advances; the whole pipeline holds only while the skid register is full.
module pressure_temp_compensation import ptc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [15:0]         i_raw_temp,
    input  logic [18:0]         i_raw_pressure,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [15:0]  o_temp_tenths,
    output logic [17:0]         o_pressure_pa,
    output logic                o_div_error,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [CFG_DW-1:0]   i_cfg_data
);

    // Values that travel alongside the arithmetic from stage D on.
    typedef struct packed {
        logic [15:0] t;
        logic [18:0] up;
        logic        zerr;
        logic        b4z;
    } t_side;

    // ---------------------------------------------------------------- config
    logic [47:0] r_cal_ac123;
    logic [47:0] r_cal_ac456;
    logic [31:0] r_cal_b12;
    logic [31:0] r_cal_mcmd;
    logic [1:0]  r_oss;

    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0]        ac4, ac5, ac6;

    assign o_cfg_ready = 1'b1;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_ac123 <= RST_AC123;
            r_cal_ac456 <= RST_AC456;
            r_cal_b12   <= RST_B1B2;
            r_cal_mcmd  <= RST_MCMD;
            r_oss       <= RST_OSS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_AC123: r_cal_ac123 <= i_cfg_data[47:0];
                CFG_AC456: r_cal_ac456 <= i_cfg_data[47:0];
                CFG_B1B2:  r_cal_b12   <= i_cfg_data[31:0];
                CFG_MCMD:  r_cal_mcmd  <= i_cfg_data[31:0];
                CFG_OSS:   r_oss       <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Unpack the calibration coefficients.
    assign ac1 = $signed(r_cal_ac123[47:32]);
    assign ac2 = $signed(r_cal_ac123[31:16]);
    assign ac3 = $signed(r_cal_ac123[15:0]);
    assign ac4 = r_cal_ac456[47:32];
    assign ac5 = r_cal_ac456[31:16];
    assign ac6 = r_cal_ac456[15:0];
    assign b1  = $signed(r_cal_b12[31:16]);
    assign b2  = $signed(r_cal_b12[15:0]);
    assign mc  = $signed(r_cal_mcmd[31:16]);
    assign md  = $signed(r_cal_mcmd[15:0]);

    // ---------------------------------------------------------------- flow control
    logic en;
    logic r_s_vld;

    assign en      = ~r_s_vld;
    assign o_ready = en;

    // ---------------------------------------------------------------- declarations
    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_f_vld, r_g_vld;
    logic r_h_vld, r_i_vld, r_j_vld, r_k_vld, r_m_vld, r_n_vld, r_o_vld;
    logic r_p_vld, r_q_vld;

    logic signed [16:0] a_diff;
    logic signed [33:0] n_a_prod, r_a_prod;
    logic [18:0]        r_a_up;

    logic signed [18:0] b_x1, r_b_x1;
    logic signed [19:0] n_b_den, r_b_den;
    logic [18:0]        r_b_up;

    logic [19:0]        d1_den_abs;
    logic [16:0]        d1_mc_abs;
    t_div_lane          d1_in, d1_out;

    logic signed [18:0] c_x1;
    logic signed [27:0] c_qmag, c_x2;
    logic signed [28:0] n_c_b5, r_c_b5;
    logic [18:0]        r_c_up;
    logic               r_c_zerr;

    logic signed [29:0] d_tsum;
    logic signed [25:0] d_tq;
    logic signed [15:0] n_d_t;
    logic signed [28:0] d_b6_full;
    logic signed [27:0] n_d_b6, r_d_b6;
    t_side              n_d_side, r_d_side;

    logic signed [55:0] n_e_b6sq, r_e_b6sq;
    logic signed [43:0] n_e_ac2, r_e_ac2, n_e_ac3, r_e_ac3;
    t_side              r_e_side;

    logic signed [42:0] n_f_sq, r_f_sq;
    logic signed [32:0] n_f_x2p, r_f_x2p;
    logic signed [30:0] n_f_x1q, r_f_x1q;
    t_side              r_f_side;

    logic signed [58:0] n_g_b2sq, r_g_b2sq, n_g_b1sq, r_g_b1sq;
    logic signed [32:0] r_g_x2p;
    logic signed [30:0] r_g_x1q;
    t_side              r_g_side;

    logic signed [47:0] h_x1;
    logic signed [17:0] h_ac1x4;
    logic signed [42:0] h_x2;
    logic signed [49:0] n_h_s, r_h_s;
    logic signed [43:0] n_h_y, r_h_y;
    t_side              r_h_side;

    logic signed [53:0] i_v, i_va;
    logic [31:0]        n_i_b3, r_i_b3, n_i_w, r_i_w;
    t_side              r_i_side;

    logic [47:0]        j_b4_full;
    logic [31:0]        n_j_b4p, r_j_b4p, n_j_diff, r_j_diff;
    t_side              r_j_side;

    logic [15:0]        k_scale;
    logic [47:0]        k_b7_full;
    logic [31:0]        n_k_b7, r_k_b7;
    logic [16:0]        n_k_b4, r_k_b4;
    t_side              r_k_side;

    logic               d2_big;
    t_div_lane          d2_in, d2_out;

    logic [32:0]        n_m_p, r_m_p;
    t_side              n_m_side, r_m_side;

    logic [49:0]        n_n_sq, r_n_sq;
    logic signed [47:0] n_n_m, r_n_m;
    logic [32:0]        r_n_p;
    t_side              r_n_side;

    logic [61:0]        o_x1_full;
    logic [45:0]        n_o_x1, r_o_x1;
    logic signed [31:0] n_o_x2, r_o_x2;
    logic [32:0]        r_o_p;
    t_side              r_o_side;

    logic signed [47:0] p_sum;
    logic signed [43:0] n_p_c, r_p_c;
    logic [32:0]        r_p_p;
    t_side              r_p_side;

    logic signed [44:0] q_pf;
    logic [17:0]        n_q_pa, r_q_pa;
    logic [15:0]        r_q_t;
    logic               r_q_err;

    logic [17:0]        r_s_pa;
    logic [15:0]        r_s_t;
    logic               r_s_err;

    // ---------------------------------------------------------------- stage A
    // (ut - ac6) * ac5
    assign a_diff   = $signed({1'b0, i_raw_temp}) - $signed({1'b0, ac6});
    assign n_a_prod = a_diff * $signed({1'b0, ac5});

    // ---------------------------------------------------------------- stage B
    // x1 and the temperature divisor x1 + md.
    assign b_x1    = $signed(r_a_prod[33:15]);
    assign n_b_den = b_x1 + md;

    // Temperature divider: |mc * 2048| / |x1 + md|, sign and zero flag ride along.
    assign d1_den_abs = r_b_den[19] ? (~r_b_den + 20'd1) : r_b_den;
    assign d1_mc_abs  = mc[15] ? (~{mc[15], mc} + 17'd1) : {1'b0, mc};

    always_comb begin
        d1_in      = '0;
        d1_in.vld  = r_b_vld;
        d1_in.nq   = {4'd0, d1_mc_abs, 11'd0};
        d1_in.den  = d1_den_abs[DIV_DW-1:0];
        d1_in.pass = {r_b_x1, r_b_up, mc[15] ^ r_b_den[19], r_b_den == '0};
    end

    ptc_divider u_div_temp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_lane (d1_in),
        .o_lane (d1_out)
    );

    // ---------------------------------------------------------------- stage C
    // Signed quotient x2 (zero when the divisor was zero) and b5.
    assign c_x1   = $signed(d1_out.pass[39:21]);
    assign c_qmag = $signed({1'b0, d1_out.nq[26:0]});

    always_comb begin
        if (d1_out.pass[0]) begin
            c_x2 = '0;
        end else if (d1_out.pass[1]) begin
            c_x2 = -c_qmag;
        end else begin
            c_x2 = c_qmag;
        end
    end

    assign n_c_b5 = c_x1 + c_x2;

    // ---------------------------------------------------------------- stage D
    // Temperature in tenths with saturation, and b6.
    assign d_tsum = r_c_b5 + T_ROUND;
    assign d_tq   = $signed(d_tsum[29:4]);

    always_comb begin
        if (d_tq > T_MAX) begin
            n_d_t = T_MAX;
        end else if (d_tq < T_MIN) begin
            n_d_t = T_MIN;
        end else begin
            n_d_t = $signed(d_tq[15:0]);
        end
    end

    assign d_b6_full = r_c_b5 - B6_OFFSET;
    assign n_d_b6    = $signed(d_b6_full[27:0]);

    always_comb begin
        n_d_side      = '0;
        n_d_side.t    = n_d_t;
        n_d_side.up   = r_c_up;
        n_d_side.zerr = r_c_zerr;
    end

    // ---------------------------------------------------------------- stage E
    // b6 * b6, ac2 * b6, ac3 * b6.
    assign n_e_b6sq = r_d_b6 * r_d_b6;
    assign n_e_ac2  = ac2 * r_d_b6;
    assign n_e_ac3  = ac3 * r_d_b6;

    // ---------------------------------------------------------------- stage F
    assign n_f_sq  = $signed(r_e_b6sq[54:12]);
    assign n_f_x2p = $signed(r_e_ac2[43:11]);
    assign n_f_x1q = $signed(r_e_ac3[43:13]);

    // ---------------------------------------------------------------- stage G
    assign n_g_b2sq = b2 * r_f_sq;
    assign n_g_b1sq = b1 * r_f_sq;

    // ---------------------------------------------------------------- stage H
    // Sum for b3 and the rounded sum for b4.
    assign h_x1    = $signed(r_g_b2sq[58:11]);
    assign h_ac1x4 = $signed({ac1, 2'b00});
    assign n_h_s   = h_x1 + r_g_x2p + h_ac1x4;
    assign h_x2    = $signed(r_g_b1sq[58:16]);
    assign n_h_y   = r_g_x1q + h_x2 + RND_TWO;

    // ---------------------------------------------------------------- stage I
    // b3 divides by four toward zero; only its low 32 bits matter downstream.
    assign i_v    = (r_h_s <<< r_oss) + RND_TWO;
    assign i_va   = i_v[53] ? (i_v + RND_THREE) : i_v;
    assign n_i_b3 = i_va[33:2];
    assign n_i_w  = r_h_y[33:2] + W_OFFSET;

    // ---------------------------------------------------------------- stage J
    // ac4 * (x3 + 32768) and up - b3, both modulo 2^32.
    assign j_b4_full = ac4 * r_i_w;
    assign n_j_b4p   = j_b4_full[31:0];
    assign n_j_diff  = {13'd0, r_i_side.up} - r_i_b3;

    // ---------------------------------------------------------------- stage K
    assign k_scale   = P_SCALE >> r_oss;
    assign k_b7_full = r_j_diff * k_scale;
    assign n_k_b7    = k_b7_full[31:0];
    assign n_k_b4    = r_j_b4p[31:15];

    // Pressure divider: 2*b7 / b4 below 0x80000000, else b7 / b4 doubled afterwards.
    assign d2_big = r_k_b7[31];

    always_comb begin
        d2_in      = '0;
        d2_in.vld  = r_k_vld;
        d2_in.nq   = d2_big ? r_k_b7 : {r_k_b7[30:0], 1'b0};
        d2_in.den  = {1'b0, r_k_b4};
        d2_in.pass = {21'd0, r_k_side.t, r_k_side.zerr, d2_big, r_k_b4 == '0};
    end

    ptc_divider u_div_press (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_lane (d2_in),
        .o_lane (d2_out)
    );

    // ---------------------------------------------------------------- stage M
    assign n_m_p = d2_out.pass[1] ? {d2_out.nq, 1'b0} : {1'b0, d2_out.nq};

    always_comb begin
        n_m_side      = '0;
        n_m_side.t    = d2_out.pass[18:3];
        n_m_side.zerr = d2_out.pass[2];
        n_m_side.b4z  = d2_out.pass[0];
    end

    // ---------------------------------------------------------------- stage N
    assign n_n_sq = r_m_p[32:8] * r_m_p[32:8];
    assign n_n_m  = P_C2 * $signed({1'b0, r_m_p});

    // ---------------------------------------------------------------- stage O
    assign o_x1_full = r_n_sq * P_C1;
    assign n_o_x1    = o_x1_full[61:16];
    assign n_o_x2    = $signed(r_n_m[47:16]);

    // ---------------------------------------------------------------- stage P
    assign p_sum = $signed({1'b0, r_o_x1}) + r_o_x2 + P_C3;
    assign n_p_c = $signed(p_sum[47:4]);

    // ---------------------------------------------------------------- stage Q
    // Final correction and saturation; a zero b4 forces zero pressure.
    assign q_pf = $signed({1'b0, r_p_p}) + r_p_c;

    always_comb begin
        if (r_p_side.b4z || q_pf < 0) begin
            n_q_pa = '0;
        end else if (q_pf > PA_MAX) begin
            n_q_pa = PA_MAX[17:0];
        end else begin
            n_q_pa = q_pf[17:0];
        end
    end

    // ---------------------------------------------------------------- valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
            r_i_vld <= 1'b0;
            r_j_vld <= 1'b0;
            r_k_vld <= 1'b0;
            r_m_vld <= 1'b0;
            r_n_vld <= 1'b0;
            r_o_vld <= 1'b0;
            r_p_vld <= 1'b0;
            r_q_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= d1_out.vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
            r_i_vld <= r_h_vld;
            r_j_vld <= r_i_vld;
            r_k_vld <= r_j_vld;
            r_m_vld <= d2_out.vld;
            r_n_vld <= r_m_vld;
            r_o_vld <= r_n_vld;
            r_p_vld <= r_o_vld;
            r_q_vld <= r_p_vld;
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_prod <= n_a_prod;
            r_a_up   <= i_raw_pressure;

            r_b_x1  <= b_x1;
            r_b_den <= n_b_den;
            r_b_up  <= r_a_up;

            r_c_b5   <= n_c_b5;
            r_c_up   <= d1_out.pass[20:2];
            r_c_zerr <= d1_out.pass[0];

            r_d_b6   <= n_d_b6;
            r_d_side <= n_d_side;

            r_e_b6sq <= n_e_b6sq;
            r_e_ac2  <= n_e_ac2;
            r_e_ac3  <= n_e_ac3;
            r_e_side <= r_d_side;

            r_f_sq   <= n_f_sq;
            r_f_x2p  <= n_f_x2p;
            r_f_x1q  <= n_f_x1q;
            r_f_side <= r_e_side;

            r_g_b2sq <= n_g_b2sq;
            r_g_b1sq <= n_g_b1sq;
            r_g_x2p  <= r_f_x2p;
            r_g_x1q  <= r_f_x1q;
            r_g_side <= r_f_side;

            r_h_s    <= n_h_s;
            r_h_y    <= n_h_y;
            r_h_side <= r_g_side;

            r_i_b3   <= n_i_b3;
            r_i_w    <= n_i_w;
            r_i_side <= r_h_side;

            r_j_b4p  <= n_j_b4p;
            r_j_diff <= n_j_diff;
            r_j_side <= r_i_side;

            r_k_b7   <= n_k_b7;
            r_k_b4   <= n_k_b4;
            r_k_side <= r_j_side;

            r_m_p    <= n_m_p;
            r_m_side <= n_m_side;

            r_n_sq   <= n_n_sq;
            r_n_m    <= n_n_m;
            r_n_p    <= r_m_p;
            r_n_side <= r_m_side;

            r_o_x1   <= n_o_x1;
            r_o_x2   <= n_o_x2;
            r_o_p    <= r_n_p;
            r_o_side <= r_n_side;

            r_p_c    <= n_p_c;
            r_p_p    <= r_o_p;
            r_p_side <= r_o_side;

            r_q_pa  <= n_q_pa;
            r_q_t   <= r_p_side.t;
            r_q_err <= r_p_side.zerr | r_p_side.b4z;
        end
    end

    // ---------------------------------------------------------------- skid register
    // Catches the last stage's result when it is not taken as the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (r_s_vld) begin
            if (i_ready) begin
                r_s_vld <= 1'b0;
            end
        end else if (r_q_vld && !i_ready) begin
            r_s_vld <= 1'b1;
            r_s_pa  <= r_q_pa;
            r_s_t   <= r_q_t;
            r_s_err <= r_q_err;
        end
    end

    // Result port: the skid register has priority since it holds the older result.
    assign o_valid       = r_s_vld | r_q_vld;
    assign o_pressure_pa = r_s_vld ? r_s_pa : r_q_pa;
    assign o_temp_tenths = $signed(r_s_vld ? r_s_t : r_q_t);
    assign o_div_error   = r_s_vld ? r_s_err : r_q_err;

endmodule

// ===== hw/rtl/ptc_div_cell.sv =====
// One restoring division step: produces one quotient bit and passes the slot on.
// Depends on ptc_pkg for the lane type and widths.
module ptc_div_cell import ptc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_div_lane i_lane,
    output t_div_lane o_lane
);

    logic [DIV_DW:0] trial;
    logic [DIV_DW:0] diff;
    logic            fits;
    t_div_lane       r_lane;
    t_div_lane       n_lane;

    // Bring down the next dividend bit and try to subtract the divisor.
    assign trial = {i_lane.rem, i_lane.nq[DIV_NW-1]};
    assign diff  = trial - {1'b0, i_lane.den};
    assign fits  = trial >= {1'b0, i_lane.den};

    always_comb begin
        n_lane     = i_lane;
        n_lane.rem = fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
        n_lane.nq  = {i_lane.nq[DIV_NW-2:0], fits};
    end

    // Slot register; only the valid bit is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.vld <= 1'b0;
        end else if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

// ===== hw/rtl/ptc_divider.sv =====
// Unsigned divider built as a row of restoring cells, one quotient bit per cell.
// Depends on ptc_pkg and ptc_div_cell.
module ptc_divider import ptc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_div_lane i_lane,
    output t_div_lane o_lane
);

    t_div_lane w_lane [DIV_STEPS+1];

    assign w_lane[0] = i_lane;

    // Each cell hands its slot to the next one every cycle while i_en is high.
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
        ptc_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (i_en),
            .i_lane (w_lane[g]),
            .o_lane (w_lane[g+1])
        );
    end

    assign o_lane = w_lane[DIV_STEPS];

endmodule

// ===== hw/rtl/ptc_checker.sv =====
// Port-level checks for the compensation block, attached to the top level by bind.
// Depends only on the top level's result and handshake ports.
module ptc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input logic signed [15:0]  o_temp_tenths,
    input logic [17:0]         o_pressure_pa,
    input logic                o_div_error
);

    // A result offered and not taken is still offered in the next cycle.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result withdrawn before transfer");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_temp_tenths) && $stable(o_pressure_pa)
                                && $stable(o_div_error))
        else $error("result changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

    // Input back-pressure only arises from a refused result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && $past(o_valid && !i_ready))
        else $error("input stalled without a refused result");

endmodule

bind pressure_temp_compensation ptc_checker u_ptc_checker (.*);
